[src/dcbp_pkg.sv]
package dcbp_pkg;

    // Network shape and history length.
    localparam int LAYERS       = 4;
    localparam int TAPS         = 8;
    localparam int HISTORY_BITS = 64;

    // Stored weights are signed and held within these bounds.
    localparam int WEIGHT_W   = 8;
    localparam int WEIGHT_MAX = 127;
    localparam int WEIGHT_MIN = -128;

    // Configuration registers.
    localparam int DIL_REGS   = 4;
    localparam int DIL_W      = 2;
    localparam int DILATION_W = 6;
    localparam int THRESH_W   = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    // Result confidence field.
    localparam int CONF_W   = 20;
    localparam int CONF_MAX = (1 << CONF_W) - 1;

    // Derived counter and index widths.
    localparam int LAYER_W    = (LAYERS > 1) ? $clog2(LAYERS) : 1;
    localparam int TAP_W      = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int HIST_IDX_W = $clog2(HISTORY_BITS);
    localparam int TAP_IDX_W  = TAP_W + DILATION_W;

    // Derived arithmetic widths: layer sum, clipped layer output, output
    // product and the running accumulator of the shared adder.
    localparam int LSUM_W = WEIGHT_W + $clog2(TAPS + 1) + 1;
    localparam int OUTS_W = LSUM_W - 1;
    localparam int PROD_W = WEIGHT_W + OUTS_W + 1;
    localparam int ACC_W  = PROD_W + $clog2(LAYERS + 1) + 1;

    typedef logic signed [WEIGHT_W-1:0] weight_t;
    typedef logic signed [ACC_W-1:0]    acc_t;
    typedef logic [OUTS_W-1:0]          outs_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD  = 3'd0,
        CFG_DIL_LAYER0 = 3'd1,
        CFG_DIL_LAYER1 = 3'd2,
        CFG_DIL_LAYER2 = 3'd3,
        CFG_DIL_LAYER3 = 3'd4
    } cfg_reg_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL_TAP,
        ST_EVAL_MAC,
        ST_MAG,
        ST_DECIDE,
        ST_TRAIN_BIAS,
        ST_TRAIN_TAP,
        ST_TRAIN_OW,
        ST_TRAIN_OB,
        ST_RESP
    } state_t;

    // Sequencer to datapath.
    typedef struct packed {
        state_t             state;
        logic [LAYER_W-1:0] layer;
        logic [TAP_W-1:0]   tap;
        logic               first_tap;
        logic               first_layer;
        logic               load_out;
    } ctrl_t;

    // Datapath to sequencer.
    typedef struct packed {
        logic train;
        logic out_free;
    } stat_t;

endpackage

[src/dcbp_alu.sv]
module dcbp_alu (
    input  dcbp_pkg::acc_t    a,
    input  dcbp_pkg::acc_t    b,
    input  logic              neg,
    output dcbp_pkg::acc_t    sum,
    output dcbp_pkg::weight_t sat
);

    // One adder: a plus b, or a minus b through inversion and carry in.
    always_comb begin
        sum = a + (b ^ {dcbp_pkg::ACC_W{neg}}) + dcbp_pkg::acc_t'(neg);
    end

    // Clamp the sum into the weight range for training writes.
    always_comb begin
        if (sum > dcbp_pkg::acc_t'(dcbp_pkg::WEIGHT_MAX)) begin
            sat = dcbp_pkg::weight_t'(dcbp_pkg::WEIGHT_MAX);
        end else if (sum < dcbp_pkg::acc_t'(dcbp_pkg::WEIGHT_MIN)) begin
            sat = dcbp_pkg::weight_t'(dcbp_pkg::WEIGHT_MIN);
        end else begin
            sat = sum[dcbp_pkg::WEIGHT_W-1:0];
        end
    end

endmodule

[src/dcbp_ctrl.sv]
module dcbp_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  dcbp_pkg::stat_t stat,
    output dcbp_pkg::ctrl_t ctrl
);

    dcbp_pkg::state_t                 state_reg, state_next;
    logic [dcbp_pkg::LAYER_W-1:0]     layer_reg, layer_next;
    logic [dcbp_pkg::TAP_W-1:0]       tap_reg, tap_next;
    logic                             last_tap;
    logic                             last_layer;

    assign last_tap   = (tap_reg == dcbp_pkg::TAP_W'(dcbp_pkg::TAPS - 1));
    assign last_layer = (layer_reg == dcbp_pkg::LAYER_W'(dcbp_pkg::LAYERS - 1));

    // State register and loop counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dcbp_pkg::ST_IDLE;
            layer_reg <= '0;
            tap_reg   <= '0;
        end else begin
            state_reg <= state_next;
            layer_reg <= layer_next;
            tap_reg   <= tap_next;
        end
    end

    // Next state: evaluate all layers, then train when asked, then respond.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dcbp_pkg::ST_IDLE: begin
                if (s_valid) state_next = dcbp_pkg::ST_EVAL_TAP;
            end
            dcbp_pkg::ST_EVAL_TAP: begin
                if (last_tap) state_next = dcbp_pkg::ST_EVAL_MAC;
            end
            dcbp_pkg::ST_EVAL_MAC: begin
                state_next = last_layer ? dcbp_pkg::ST_MAG : dcbp_pkg::ST_EVAL_TAP;
            end
            dcbp_pkg::ST_MAG: begin
                state_next = dcbp_pkg::ST_DECIDE;
            end
            dcbp_pkg::ST_DECIDE: begin
                state_next = stat.train ? dcbp_pkg::ST_TRAIN_BIAS : dcbp_pkg::ST_RESP;
            end
            dcbp_pkg::ST_TRAIN_BIAS: begin
                state_next = dcbp_pkg::ST_TRAIN_TAP;
            end
            dcbp_pkg::ST_TRAIN_TAP: begin
                if (last_tap) state_next = dcbp_pkg::ST_TRAIN_OW;
            end
            dcbp_pkg::ST_TRAIN_OW: begin
                state_next = last_layer ? dcbp_pkg::ST_TRAIN_OB : dcbp_pkg::ST_TRAIN_BIAS;
            end
            dcbp_pkg::ST_TRAIN_OB: begin
                state_next = dcbp_pkg::ST_RESP;
            end
            dcbp_pkg::ST_RESP: begin
                if (stat.out_free) state_next = dcbp_pkg::ST_IDLE;
            end
            default: begin
                state_next = dcbp_pkg::ST_IDLE;
            end
        endcase
    end

    // Layer and tap counters walk the weights in the same order in both passes.
    always_comb begin
        layer_next = layer_reg;
        tap_next   = tap_reg;
        case (state_reg) inside
            dcbp_pkg::ST_IDLE: begin
                layer_next = '0;
                tap_next   = '0;
            end
            dcbp_pkg::ST_EVAL_TAP, dcbp_pkg::ST_TRAIN_TAP: begin
                if (!last_tap) tap_next = tap_reg + 1'b1;
            end
            dcbp_pkg::ST_EVAL_MAC, dcbp_pkg::ST_TRAIN_OW: begin
                tap_next   = '0;
                layer_next = last_layer ? '0 : layer_reg + 1'b1;
            end
            dcbp_pkg::ST_TRAIN_BIAS: begin
                tap_next = '0;
            end
            default: begin
            end
        endcase
    end

    // Outputs to the datapath.
    always_comb begin
        s_ready          = (state_reg == dcbp_pkg::ST_IDLE);
        ctrl.state       = state_reg;
        ctrl.layer       = layer_reg;
        ctrl.tap         = tap_reg;
        ctrl.first_tap   = (tap_reg == '0);
        ctrl.first_layer = (layer_reg == '0);
        ctrl.load_out    = (state_reg == dcbp_pkg::ST_RESP) && stat.out_free;
    end

endmodule

[src/dilated_conv_branch_predictor.sv]
// Channel   Direction  Handshake          Payload
// s_        in         s_valid/s_ready    s_op, s_taken
// m_        out        m_valid/m_ready    m_predicted_taken, m_confidence, m_trained
// cfg_      in         cfg_wr_en          cfg_index, cfg_wr_data
//
// A predict transaction, or a resolve that does not train, runs from acceptance through
// evaluation and the response state; a training resolve also runs the training pass.
// The pace is set by the one shared adder: one tap per cycle over LAYERS*TAPS
// taps plus one multiply-accumulate per layer, then one weight per cycle in training.
// Synchronous active-low reset clears history and weights and restores the
// configuration defaults.
// A result waits in the output register; while it is not taken, the next one holds
// in the response state and no new transaction is accepted.
module dilated_conv_branch_predictor (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_op,
    input  logic                                s_taken,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_predicted_taken,
    output logic [dcbp_pkg::CONF_W-1:0]         m_confidence,
    output logic                                m_trained,
    input  logic                                cfg_wr_en,
    input  logic [dcbp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dcbp_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);

    dcbp_pkg::ctrl_t ctrl;
    dcbp_pkg::stat_t stat;

    // Configuration.
    logic [dcbp_pkg::THRESH_W-1:0]   thr_reg;
    logic [dcbp_pkg::DILATION_W-1:0] dil_reg [dcbp_pkg::DIL_REGS];

    // Predictor state.
    logic [dcbp_pkg::HISTORY_BITS-1:0] hist_reg;
    dcbp_pkg::weight_t tw_reg [dcbp_pkg::LAYERS][dcbp_pkg::TAPS];
    dcbp_pkg::weight_t lb_reg [dcbp_pkg::LAYERS];
    dcbp_pkg::weight_t ow_reg [dcbp_pkg::LAYERS];
    dcbp_pkg::weight_t ob_reg;

    // Per-transaction working registers.
    logic                          op_reg;
    logic                          taken_reg;
    logic                          trained_reg;
    dcbp_pkg::acc_t                acc_reg;
    dcbp_pkg::acc_t                total_reg;
    dcbp_pkg::outs_t               outs_reg [dcbp_pkg::LAYERS];
    logic [dcbp_pkg::ACC_W-1:0]    mag_reg;

    // Output register.
    logic                          m_valid_reg;
    logic                          m_pred_reg;
    logic [dcbp_pkg::CONF_W-1:0]   m_conf_reg;
    logic                          m_trained_reg;

    // Shared adder operands.
    dcbp_pkg::acc_t    alu_a;
    dcbp_pkg::acc_t    alu_b;
    logic              alu_neg;
    dcbp_pkg::acc_t    alu_sum;
    dcbp_pkg::weight_t alu_sat;

    // Tap selection.
    logic [dcbp_pkg::DILATION_W-1:0] dil_sel;
    logic [dcbp_pkg::TAP_IDX_W-1:0]  tap_idx;
    logic                            tap_skip;
    logic                            hist_bit;
    dcbp_pkg::weight_t               tap_w;
    logic signed [dcbp_pkg::PROD_W-1:0] prod;
    logic                            total_neg;

    dcbp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    dcbp_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .neg (alu_neg),
        .sum (alu_sum),
        .sat (alu_sat)
    );

    // History index of the current tap; taps past the history are skipped.
    assign dil_sel  = dil_reg[dcbp_pkg::DIL_W'(ctrl.layer % dcbp_pkg::DIL_REGS)];
    assign tap_idx  = dcbp_pkg::TAP_IDX_W'(ctrl.tap) * dcbp_pkg::TAP_IDX_W'(dil_sel);
    assign tap_skip = (tap_idx >= dcbp_pkg::TAP_IDX_W'(dcbp_pkg::HISTORY_BITS));
    assign hist_bit = hist_reg[tap_idx[dcbp_pkg::HIST_IDX_W-1:0]];
    assign tap_w    = tw_reg[ctrl.layer][ctrl.tap];

    // Output weight times clipped layer output.
    assign prod      = ow_reg[ctrl.layer] * $signed({1'b0, outs_reg[ctrl.layer]});
    assign total_neg = total_reg[dcbp_pkg::ACC_W-1];

    // Operand selection for the shared adder.
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_neg = 1'b0;
        case (ctrl.state)
            dcbp_pkg::ST_EVAL_TAP: begin
                alu_a   = ctrl.first_tap ? dcbp_pkg::acc_t'(lb_reg[ctrl.layer]) : acc_reg;
                alu_b   = tap_skip ? '0 : dcbp_pkg::acc_t'(tap_w);
                alu_neg = !hist_bit;
            end
            dcbp_pkg::ST_EVAL_MAC: begin
                alu_a   = ctrl.first_layer ? dcbp_pkg::acc_t'(ob_reg) : total_reg;
                alu_b   = dcbp_pkg::acc_t'(prod);
            end
            dcbp_pkg::ST_MAG: begin
                alu_b   = total_reg;
                alu_neg = 1'b1;
            end
            dcbp_pkg::ST_TRAIN_BIAS: begin
                alu_a   = dcbp_pkg::acc_t'(lb_reg[ctrl.layer]);
                alu_b   = dcbp_pkg::acc_t'(1);
                alu_neg = !taken_reg;
            end
            dcbp_pkg::ST_TRAIN_TAP: begin
                alu_a   = dcbp_pkg::acc_t'(tap_w);
                alu_b   = tap_skip ? '0 : dcbp_pkg::acc_t'(1);
                alu_neg = (taken_reg != hist_bit);
            end
            dcbp_pkg::ST_TRAIN_OW: begin
                alu_a   = dcbp_pkg::acc_t'(ow_reg[ctrl.layer]);
                alu_b   = dcbp_pkg::acc_t'({1'b0, outs_reg[ctrl.layer]});
                alu_neg = !taken_reg;
            end
            dcbp_pkg::ST_TRAIN_OB: begin
                alu_a   = dcbp_pkg::acc_t'(ob_reg);
                alu_b   = dcbp_pkg::acc_t'(1);
                alu_neg = !taken_reg;
            end
            default: begin
            end
        endcase
    end

    // Training decision and output-register availability.
    always_comb begin
        stat.train = op_reg &&
                     ((!total_neg != taken_reg) ||
                      (mag_reg < dcbp_pkg::ACC_W'(thr_reg)));
        stat.out_free = !m_valid_reg || m_ready;
    end

    // Configuration writes; indexes past the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg    <= dcbp_pkg::THRESH_W'(32);
            dil_reg[0] <= dcbp_pkg::DILATION_W'(1);
            dil_reg[1] <= dcbp_pkg::DILATION_W'(2);
            dil_reg[2] <= dcbp_pkg::DILATION_W'(4);
            dil_reg[3] <= dcbp_pkg::DILATION_W'(8);
        end else if (cfg_wr_en) begin
            unique case (cfg_index) inside
                dcbp_pkg::CFG_THRESHOLD: begin
                    thr_reg <= cfg_wr_data[dcbp_pkg::THRESH_W-1:0];
                end
                dcbp_pkg::CFG_DIL_LAYER0, dcbp_pkg::CFG_DIL_LAYER1,
                dcbp_pkg::CFG_DIL_LAYER2, dcbp_pkg::CFG_DIL_LAYER3: begin
                    dil_reg[dcbp_pkg::DIL_W'(cfg_index - dcbp_pkg::CFG_DIL_LAYER0)] <=
                        cfg_wr_data[dcbp_pkg::DILATION_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Weight updates, one weight per training cycle, saturated by the adder.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int l = 0; l < dcbp_pkg::LAYERS; l++) begin
                for (int k = 0; k < dcbp_pkg::TAPS; k++) begin
                    tw_reg[l][k] <= '0;
                end
                lb_reg[l] <= '0;
                ow_reg[l] <= '0;
            end
            ob_reg <= '0;
        end else begin
            case (ctrl.state)
                dcbp_pkg::ST_TRAIN_BIAS: lb_reg[ctrl.layer]          <= alu_sat;
                dcbp_pkg::ST_TRAIN_TAP:  tw_reg[ctrl.layer][ctrl.tap] <= alu_sat;
                dcbp_pkg::ST_TRAIN_OW:   ow_reg[ctrl.layer]          <= alu_sat;
                dcbp_pkg::ST_TRAIN_OB:   ob_reg                      <= alu_sat;
                default: begin
                end
            endcase
        end
    end

    // History shifts in the outcome when a resolve transaction completes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg <= '0;
        end else if (ctrl.load_out && op_reg) begin
            hist_reg <= {hist_reg[dcbp_pkg::HISTORY_BITS-2:0], taken_reg};
        end
    end

    // Transaction fields are captured on acceptance; the training flag in the decide state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg      <= 1'b0;
            taken_reg   <= 1'b0;
            trained_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                op_reg    <= s_op;
                taken_reg <= s_taken;
            end
            if (ctrl.state == dcbp_pkg::ST_DECIDE) begin
                trained_reg <= stat.train;
            end
        end
    end

    // Evaluation accumulators: layer sums, clipped outputs, total and magnitude.
    always_ff @(posedge aclk) begin
        case (ctrl.state)
            dcbp_pkg::ST_EVAL_TAP: begin
                acc_reg <= alu_sum;
                outs_reg[ctrl.layer] <= alu_sum[dcbp_pkg::ACC_W-1] ?
                                        '0 : alu_sum[dcbp_pkg::OUTS_W-1:0];
            end
            dcbp_pkg::ST_EVAL_MAC: begin
                total_reg <= alu_sum;
            end
            dcbp_pkg::ST_MAG: begin
                mag_reg <= total_neg ? alu_sum : total_reg;
            end
            default: begin
            end
        endcase
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_out) begin
            m_pred_reg    <= !total_neg;
            m_conf_reg    <= (mag_reg > dcbp_pkg::ACC_W'(dcbp_pkg::CONF_MAX)) ?
                             dcbp_pkg::CONF_W'(dcbp_pkg::CONF_MAX) :
                             mag_reg[dcbp_pkg::CONF_W-1:0];
            m_trained_reg <= trained_reg;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_predicted_taken = m_pred_reg;
    assign m_confidence      = m_conf_reg;
    assign m_trained         = m_trained_reg;

    // A new transaction is never accepted in the cycle after one was accepted.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted twice in a row");

    // History moves only when a resolve result is loaded.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(ctrl.load_out && op_reg) |=> $stable(hist_reg))
        else $error("history changed outside a resolve");

    // The output bias changes only in its training step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.state != dcbp_pkg::ST_TRAIN_OB |=> $stable(ob_reg))
        else $error("output bias changed outside training");

    // A predict transaction never reports training.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.load_out && !op_reg |=> m_valid && !m_trained)
        else $error("predict result flagged as trained");

endmodule

[sim/tb_dilated_conv_branch_predictor.sv]
module tb_dilated_conv_branch_predictor;

    // Branch operation carried by s_op.
    typedef enum bit {
        OP_PREDICT = 1'b0,
        OP_RESOLVE = 1'b1
    } branch_op_t;

    // One result transaction as the block should return it.
    typedef struct packed {
        logic                        predicted_taken;
        logic [dcbp_pkg::CONF_W-1:0] confidence;
        logic                        trained;
    } branch_result_t;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_valid;
    logic                            s_ready;
    logic                            s_op;
    logic                            s_taken;
    logic                            m_valid;
    logic                            m_ready;
    logic                            m_predicted_taken;
    logic [dcbp_pkg::CONF_W-1:0]     m_confidence;
    logic                            m_trained;
    logic                            cfg_wr_en;
    logic [dcbp_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [dcbp_pkg::CFG_DATA_W-1:0] cfg_wr_data;

    // Expected results in acceptance order.
    branch_result_t pending_results[$];
    branch_result_t oldest_result;
    int             failures;

    // Traffic shaping shared between the stimulus thread and the receiver.
    bit no_idle;
    int hold_requests;
    int holds_done;
    int hold_left;
    int stuck_cycles;

    // Predictor state: configuration, history and network weights.
    logic [dcbp_pkg::THRESH_W-1:0]     model_threshold;
    logic [dcbp_pkg::DILATION_W-1:0]   model_dilation [dcbp_pkg::DIL_REGS];
    logic [dcbp_pkg::HISTORY_BITS-1:0] model_history;
    dcbp_pkg::weight_t                 tap_w [dcbp_pkg::LAYERS][dcbp_pkg::TAPS];
    dcbp_pkg::weight_t                 layer_b [dcbp_pkg::LAYERS];
    dcbp_pkg::weight_t                 out_w [dcbp_pkg::LAYERS];
    dcbp_pkg::weight_t                 out_b;

    dilated_conv_branch_predictor DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_op              (s_op),
        .s_taken           (s_taken),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_predicted_taken (m_predicted_taken),
        .m_confidence      (m_confidence),
        .m_trained         (m_trained),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wr_data       (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Predictor state after reset.
    function automatic void reset_model();
        model_threshold = dcbp_pkg::THRESH_W'(32);
        for (int l = 0; l < dcbp_pkg::DIL_REGS; l++) begin
            model_dilation[l] = dcbp_pkg::DILATION_W'(1 << l);
        end
        model_history = '0;
        for (int l = 0; l < dcbp_pkg::LAYERS; l++) begin
            for (int k = 0; k < dcbp_pkg::TAPS; k++) begin
                tap_w[l][k] = '0;
            end
            layer_b[l] = '0;
            out_w[l]   = '0;
        end
        out_b = '0;
    endfunction

    function automatic dcbp_pkg::weight_t clamp_weight(int v);
        if (v > dcbp_pkg::WEIGHT_MAX) begin
            return dcbp_pkg::weight_t'(dcbp_pkg::WEIGHT_MAX);
        end
        if (v < dcbp_pkg::WEIGHT_MIN) begin
            return dcbp_pkg::weight_t'(dcbp_pkg::WEIGHT_MIN);
        end
        return dcbp_pkg::weight_t'(v);
    endfunction

    // Sign that tap k of layer l contributes: +1 on a taken bit, -1 on a
    // not-taken bit, 0 when the tap reaches past the history.
    function automatic int history_term(int l, int k);
        int idx;
        idx = k * int'(model_dilation[l % dcbp_pkg::DIL_REGS]);
        if (idx >= dcbp_pkg::HISTORY_BITS) begin
            return 0;
        end
        return model_history[idx] ? 1 : -1;
    endfunction

    // Computes the result of one branch transaction and applies training and
    // the history shift to the predictor state.
    function automatic branch_result_t evaluate_branch(branch_op_t op, bit taken);
        int             layer_out [dcbp_pkg::LAYERS];
        int             total;
        int             layer_sum;
        int             mag;
        int             dir;
        branch_result_t r;
        total = int'(out_b);
        for (int l = 0; l < dcbp_pkg::LAYERS; l++) begin
            layer_sum = int'(layer_b[l]);
            for (int k = 0; k < dcbp_pkg::TAPS; k++) begin
                layer_sum += int'(tap_w[l][k]) * history_term(l, k);
            end
            layer_out[l] = (layer_sum < 0) ? 0 : layer_sum;
            total += int'(out_w[l]) * layer_out[l];
        end
        mag                 = (total < 0) ? -total : total;
        r.predicted_taken   = (total >= 0);
        r.confidence        = (mag > dcbp_pkg::CONF_MAX) ?
                              dcbp_pkg::CONF_W'(dcbp_pkg::CONF_MAX) :
                              dcbp_pkg::CONF_W'(mag);
        r.trained           = 1'b0;
        if (op == OP_RESOLVE) begin
            if (r.predicted_taken != taken || mag < int'(model_threshold)) begin
                // Training uses the layer outputs and history from before the update.
                r.trained = 1'b1;
                dir       = taken ? 1 : -1;
                out_b     = clamp_weight(int'(out_b) + dir);
                for (int l = 0; l < dcbp_pkg::LAYERS; l++) begin
                    out_w[l]   = clamp_weight(int'(out_w[l]) + dir * layer_out[l]);
                    layer_b[l] = clamp_weight(int'(layer_b[l]) + dir);
                    for (int k = 0; k < dcbp_pkg::TAPS; k++) begin
                        tap_w[l][k] = clamp_weight(int'(tap_w[l][k]) +
                                                   dir * history_term(l, k));
                    end
                end
            end
            model_history = {model_history[dcbp_pkg::HISTORY_BITS-2:0], taken};
        end
        return r;
    endfunction

    // Writes one configuration register; indexes past the last register are ignored.
    task automatic write_register(input logic [dcbp_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [dcbp_pkg::CFG_DATA_W-1:0] data);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            dcbp_pkg::CFG_THRESHOLD: begin
                model_threshold = data[dcbp_pkg::THRESH_W-1:0];
            end
            dcbp_pkg::CFG_DIL_LAYER0, dcbp_pkg::CFG_DIL_LAYER1,
            dcbp_pkg::CFG_DIL_LAYER2, dcbp_pkg::CFG_DIL_LAYER3: begin
                model_dilation[dcbp_pkg::DIL_W'(idx - dcbp_pkg::CFG_DIL_LAYER0)] =
                    data[dcbp_pkg::DILATION_W-1:0];
            end
            default: begin
            end
        endcase
        @(posedge aclk);
    endtask

    task automatic write_dilations(input int d0, input int d1, input int d2, input int d3);
        write_register(dcbp_pkg::CFG_DIL_LAYER0, dcbp_pkg::CFG_DATA_W'(d0));
        write_register(dcbp_pkg::CFG_DIL_LAYER1, dcbp_pkg::CFG_DATA_W'(d1));
        write_register(dcbp_pkg::CFG_DIL_LAYER2, dcbp_pkg::CFG_DATA_W'(d2));
        write_register(dcbp_pkg::CFG_DIL_LAYER3, dcbp_pkg::CFG_DATA_W'(d3));
    endtask

    // Offers one branch transaction, with an occasional idle gap first, and
    // records its expected result once it is accepted.
    task automatic send_branch(input branch_op_t op, input bit taken);
        int gap;
        if (!no_idle && $urandom_range(99) < 10) begin
            gap = $urandom_range(1, 100);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_op    <= op;
        s_taken <= taken;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(evaluate_branch(op, taken));
    endtask

    // Stops offering and waits until every expected result has come back.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    // Mostly resolves that follow a repeating outcome pattern, with predicts
    // and random resolves mixed in as noise.
    task automatic send_pattern_branches(input int count);
        int          period;
        logic [63:0] pattern;
        int          pick;
        period  = $urandom_range(1, 24);
        pattern = {$urandom, $urandom};
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 15) begin
                send_branch(OP_PREDICT, 1'($urandom_range(1)));
            end else if (pick < 25) begin
                send_branch(OP_RESOLVE, 1'($urandom_range(1)));
            end else begin
                send_branch(OP_RESOLVE, pattern[i % period]);
            end
        end
    endtask

    // From reset every weight is zero, so the sum is zero and the first
    // not-taken resolve mispredicts and trains.
    task automatic test_reset_state();
        send_branch(OP_PREDICT, 1'b0);
        send_branch(OP_PREDICT, 1'b1);
        send_branch(OP_RESOLVE, 1'b0);
        send_branch(OP_RESOLVE, 1'b1);
        send_branch(OP_RESOLVE, 1'b1);
        send_branch(OP_PREDICT, 1'b0);
        wait_for_results();
    endtask

    // The threshold and the first two dilations at their extremes, zero dilation, and writes to unused indexes.
    task automatic test_register_writes();
        for (int idx = dcbp_pkg::CFG_DIL_LAYER3 + 1; idx < (1 << dcbp_pkg::CFG_IDX_W);
             idx++) begin
            write_register(dcbp_pkg::CFG_IDX_W'(idx), '1);
        end
        write_register(dcbp_pkg::CFG_THRESHOLD, dcbp_pkg::CFG_DATA_W'(dcbp_pkg::CONF_MAX));
        write_dilations(0, 63, 1, 9);
        for (int i = 0; i < 6; i++) begin
            send_branch(OP_RESOLVE, i[0]);
        end
        send_branch(OP_PREDICT, 1'b1);
        wait_for_results();
        write_register(dcbp_pkg::CFG_THRESHOLD, '0);
        write_dilations(63, 0, 7, 1);
        send_branch(OP_RESOLVE, 1'b1);
        send_branch(OP_RESOLVE, 1'b0);
        send_branch(OP_PREDICT, 1'b0);
        send_branch(OP_RESOLVE, 1'b1);
        wait_for_results();
    endtask

    // With the threshold at its top every resolve trains, so long runs of one
    // outcome drive the weights into both saturation limits.
    task automatic test_weight_saturation();
        write_register(dcbp_pkg::CFG_THRESHOLD, dcbp_pkg::CFG_DATA_W'(dcbp_pkg::CONF_MAX));
        write_dilations(1, 2, 4, 8);
        for (int i = 0; i < 140; i++) begin
            send_branch(($urandom_range(9) == 0) ? OP_PREDICT : OP_RESOLVE, 1'b1);
        end
        for (int i = 0; i < 140; i++) begin
            send_branch(($urandom_range(9) == 0) ? OP_PREDICT : OP_RESOLVE, 1'b0);
        end
        wait_for_results();
    endtask

    // Several configurations, from all-zero to all-maximum dilations and
    // from a zero to a maximum threshold.
    task automatic test_random_settings();
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin
                    write_register(dcbp_pkg::CFG_THRESHOLD, '0);
                    write_dilations(0, 0, 0, 0);
                end
                1: begin
                    write_register(dcbp_pkg::CFG_THRESHOLD,
                                   dcbp_pkg::CFG_DATA_W'(dcbp_pkg::CONF_MAX));
                    write_dilations(63, 63, 63, 63);
                end
                2: begin
                    write_register(dcbp_pkg::CFG_THRESHOLD, dcbp_pkg::CFG_DATA_W'(32));
                    write_dilations(1, 2, 4, 8);
                end
                3: begin
                    write_register(dcbp_pkg::CFG_THRESHOLD, dcbp_pkg::CFG_DATA_W'($urandom));
                    write_dilations($urandom_range(63), $urandom_range(63),
                                    $urandom_range(63), $urandom_range(63));
                end
                default: begin
                    write_register(dcbp_pkg::CFG_THRESHOLD,
                                   dcbp_pkg::CFG_DATA_W'($urandom_range(0, 400)));
                    write_dilations($urandom_range(63), $urandom_range(9),
                                    $urandom_range(63), $urandom_range(9));
                end
            endcase
            send_pattern_branches(220);
            wait_for_results();
        end
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering, so the block fills and stops accepting.
    task automatic test_backpressure();
        no_idle = 1'b1;
        hold_requests++;
        for (int i = 0; i < 12; i++) begin
            send_branch(branch_op_t'($urandom_range(1)), 1'($urandom_range(1)));
        end
        wait_for_results();
        no_idle = 1'b0;
    endtask

    // A long stretch with neither side idling.
    task automatic test_full_rate();
        no_idle = 1'b1;
        write_register(dcbp_pkg::CFG_THRESHOLD, dcbp_pkg::CFG_DATA_W'(64));
        send_pattern_branches(200);
        wait_for_results();
        no_idle = 1'b0;
    endtask

    // Receiver: random stalls, requested long holds, and result checking.
    always @(posedge aclk) begin
        if (holds_done != hold_requests) begin
            holds_done <= hold_requests;
            hold_left  <= HOLD_CYCLES;
            m_ready    <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= no_idle || ($urandom_range(99) >= 10);
        end

        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with no expectation waiting");
                failures++;
            end else begin
                oldest_result = pending_results.pop_front();
                if (m_predicted_taken !== oldest_result.predicted_taken) begin
                    $error("predicted_taken mismatch: expected %0d, actual %0d",
                           oldest_result.predicted_taken, m_predicted_taken);
                    failures++;
                end
                if (m_confidence !== oldest_result.confidence) begin
                    $error("confidence mismatch: expected %0d, actual %0d",
                           oldest_result.confidence, m_confidence);
                    failures++;
                end
                if (m_trained !== oldest_result.trained) begin
                    $error("trained mismatch: expected %0d, actual %0d",
                           oldest_result.trained, m_trained);
                    failures++;
                end
            end
        end
    end

    // Watchdog: ends the run when no transaction moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_op          = 1'b0;
        s_taken       = 1'b0;
        m_ready       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_wr_data   = '0;
        no_idle       = 1'b0;
        hold_requests = 0;
        holds_done    = 0;
        hold_left     = 0;
        stuck_cycles  = 0;
        failures      = 0;
        reset_model();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_register_writes();
        test_weight_saturation();
        test_random_settings();
        test_backpressure();
        test_full_rate();

        // Let any stray result show up before the verdict.
        wait_for_results();
        repeat (100) @(posedge aclk);
        if (failures == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
src/dcbp_pkg.sv
src/dcbp_alu.sv
src/dcbp_ctrl.sv
src/dilated_conv_branch_predictor.sv
sim/tb_dilated_conv_branch_predictor.sv
